FILE: hdl/packet_class_counters_top_macros.svh
// Assertion macros shared by the packet class counter RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef PACKET_CLASS_COUNTERS_TOP_MACROS_SVH
`define PACKET_CLASS_COUNTERS_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PCC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pcc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pcc assertion failed");

`endif

FILE: hdl/pcc_pkg.sv
// Package for the packet class counters: constants, codes, payload layouts
// and small decode functions. Depends on nothing.
`default_nettype none

package pcc_pkg;

	localparam int NumCounters = 28;
	localparam int DirSpan     = 14;
	localparam int KindSpan    = 7;
	localparam int TotRows     = 2;
	localparam int ClsRows     = 14;
	localparam int RowW        = 4;
	localparam int CntW        = 64;
	localparam int OutqDepth   = 3;

	localparam logic [15:0] EthHdrBytes  = 16'd14;
	localparam logic [15:0] MinIpBytes   = 16'd20;
	localparam logic [15:0] EtherIpv4    = 16'h0800;
	localparam logic [3:0]  IpVersion4   = 4'd4;
	localparam logic [7:0]  ProtoTcp     = 8'd6;
	localparam logic [7:0]  ProtoUdp     = 8'd17;
	localparam logic [15:0] PortHttp     = 16'd80;
	localparam logic [15:0] PortSsh      = 16'd22;
	localparam logic [7:0]  PrivateOctet = 8'h0A;

	localparam int CfgIdxW  = 2;
	localparam int CfgDataW = 32;
	localparam logic [31:0] LocalAddrRst  = 32'hFFFF_FFFF;
	localparam logic [15:0] TargetPortRst = 16'd1985;
	localparam logic [31:0] MetaAddrRst   = 32'hA9FE_A9FE;

	typedef enum logic [CfgIdxW-1:0] {
		REG_LOCAL_ADDR  = 2'd0,
		REG_TARGET_PORT = 2'd1,
		REG_META_ADDR   = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		CMD_COUNT = 1'b0,
		CMD_READ  = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_SHORT_CAP = 3'd1,
		ST_NOT_IPV4  = 3'd2,
		ST_SHORT_LEN = 3'd3,
		ST_BAD_VER   = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		CLS_TOTAL   = 3'd0,
		CLS_PUBLIC  = 3'd1,
		CLS_PRIVATE = 3'd2,
		CLS_META    = 3'd3,
		CLS_SSH     = 3'd4,
		CLS_HTTP    = 3'd5,
		CLS_TARGET  = 3'd6
	} class_t;

	// Header fields as they sit in the input tdata, last member in the lowest bits.
	typedef struct packed {
		logic [4:0]  counter_select;
		logic [15:0] dst_port_num;
		logic [15:0] src_port_num;
		logic [31:0] dst_ip;
		logic [31:0] src_ip;
		logic [7:0]  ip_proto;
		logic [15:0] ip_total_len;
		logic [3:0]  ip_ver;
		logic [15:0] cap_len;
		logic [15:0] wire_len;
		logic [15:0] ether_kind;
	} hdr_t;

	typedef struct packed {
		logic [CntW-1:0] read_value;
		class_t          flow_class;
		logic            direction;
		status_t         status;
	} result_t;

	typedef struct packed {
		logic [CntW-1:0] bytes;
		logic [CntW-1:0] pkts;
	} cnt_word_t;

	typedef struct packed {
		logic   in_range;
		logic   dir;
		logic   kind;
		class_t cls;
	} sel_t;

	localparam int HdrBits   = $bits(hdr_t);
	localparam int ResBits   = $bits(result_t);
	localparam int InTdataW  = ((HdrBits + 7) / 8) * 8;
	localparam int OutTdataW = ((ResBits + 7) / 8) * 8;
	localparam int WordW     = $bits(cnt_word_t);

	function automatic logic [RowW-1:0] row_of(input logic dir, input class_t cls);
		logic [RowW-1:0] base;
		base = dir ? RowW'(KindSpan) : '0;
		return base + RowW'(cls);
	endfunction

	function automatic sel_t decode_select(input logic [4:0] sel);
		sel_t       d;
		logic [4:0] r;
		logic [4:0] c;
		d.in_range = (sel < 5'(NumCounters));
		d.dir      = (sel >= 5'(DirSpan));
		r          = d.dir ? sel - 5'(DirSpan) : sel;
		d.kind     = (r >= 5'(KindSpan));
		c          = d.kind ? r - 5'(KindSpan) : r;
		d.cls      = class_t'(c[2:0]);
		return d;
	endfunction

endpackage

`default_nettype wire

FILE: hdl/packet_class_counters_top.sv
// Packet class counters, top level. Depends on pcc_pkg, pcc_ram, pcc_outq
// and the assertion macros header.
//
// Each request on the s_ channel is either a parsed packet header to count
// (s_tuser low) or a counter read (s_tuser high, counter_select in tdata).
// Exactly one result leaves on the m_ channel for every request, in order.
// Counters live in two RAMs with 128-bit rows holding a packet and a byte
// count: a two-row RAM for the per-direction totals and a fourteen-row RAM
// for the per-direction classes. A request reads its rows in the cycle it is
// accepted; a counted packet writes them back in the next cycle, and a write
// just made is forwarded to an immediately following request on the same row.
// With an idle output, a result passes the stage-one registers into the output
// queue, whose level register raises m_tvalid. Throughput is one request per
// cycle while s_tready is high, limited by the single read port of
// each counter RAM. Results wait in a three-entry queue, so s_tready drops
// only once that queue and the stage ahead of it hold three results together.
// Reset clears all counters at once through per-row valid bits and loads
// the register defaults; configuration writes take effect on the next cycle.
`default_nettype none
`include "packet_class_counters_top_macros.svh"

module packet_class_counters_top #(
	parameter int OutqDepth = pcc_pkg::OutqDepth
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// ether_kind, wire_len, cap_len, ip_ver, ip_total_len, ip_proto, src_ip,
	// dst_ip, src_port_num, dst_port_num, counter_select, zero fill
	input  wire logic [pcc_pkg::InTdataW-1:0]   s_tdata,
	// command
	input  wire logic                           s_tuser,
	input  wire logic                           s_tvalid,
	output      logic                           s_tready,
	// status, direction, flow_class, read_value, zero fill
	output      logic [pcc_pkg::OutTdataW-1:0]  m_tdata,
	output      logic                           m_tvalid,
	input  wire logic                           m_tready,
	input  wire logic                           cfg_we,
	input  wire logic [pcc_pkg::CfgIdxW-1:0]    cfg_index,
	input  wire logic [pcc_pkg::CfgDataW-1:0]   cfg_data
);
	import pcc_pkg::*;

	localparam int LvlW = $clog2(OutqDepth + 1);

	logic [31:0] local_addr_q;
	logic [15:0] target_port_q;
	logic [31:0] svc_addr_q;

	hdr_t            hdr;
	cmd_t            cmd;
	logic            accept;
	status_t         status0;
	logic            rx0;
	class_t          cls0;
	sel_t            sel0;
	logic [15:0]     web_port;
	logic [15:0]     ssh_port;
	logic [31:0]     peer_ip;
	logic            tot_raddr;
	logic [RowW-1:0] cls_raddr;

	logic            s1_valid_q;
	cmd_t            cmd_s1;
	logic            counted_s1;
	status_t         status_s1;
	logic            dir_s1;
	class_t          cls_s1;
	sel_t            sel_s1;
	logic [16:0]     bytes_s1;
	logic            tot_addr_s1;
	logic [RowW-1:0] cls_addr_s1;
	logic            tot_vld_s1;
	logic            cls_vld_s1;

	logic [TotRows-1:0] tot_vld_q;
	logic [ClsRows-1:0] cls_vld_q;

	logic            tot_fwd_vld_s2;
	logic            tot_fwd_addr_s2;
	cnt_word_t       tot_fwd_data_s2;
	logic            cls_fwd_vld_s2;
	logic [RowW-1:0] cls_fwd_addr_s2;
	cnt_word_t       cls_fwd_data_s2;

	cnt_word_t       tot_rdata;
	cnt_word_t       cls_rdata;
	cnt_word_t       tot_old;
	cnt_word_t       cls_old;
	cnt_word_t       tot_new;
	cnt_word_t       cls_new;
	cnt_word_t       read_word;
	logic            tot_we;
	logic            cls_we;
	result_t         res_s1;
	result_t         head;
	logic [LvlW-1:0] level;
	logic [LvlW:0]   fill_sum;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_addr_q  <= LocalAddrRst;
			target_port_q <= TargetPortRst;
			svc_addr_q    <= MetaAddrRst;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_LOCAL_ADDR:  local_addr_q  <= cfg_data;
				REG_TARGET_PORT: target_port_q <= cfg_data[15:0];
				REG_META_ADDR:   svc_addr_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input side: checks, direction, class and counter row selection.
	assign hdr      = hdr_t'(s_tdata[HdrBits-1:0]);
	assign cmd      = cmd_t'(s_tuser);
	assign fill_sum = {1'b0, level} + (LvlW + 1)'(s1_valid_q);
	assign s_tready = (fill_sum < (LvlW + 1)'(OutqDepth));
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		if (cmd == CMD_READ) begin
			status0 = ST_OK;
		end else if (hdr.cap_len < EthHdrBytes) begin
			status0 = ST_SHORT_CAP;
		end else if (hdr.ether_kind != EtherIpv4) begin
			status0 = ST_NOT_IPV4;
		end else if (hdr.wire_len < MinIpBytes) begin
			status0 = ST_SHORT_LEN;
		end else if (hdr.ip_ver != IpVersion4) begin
			status0 = ST_BAD_VER;
		end else begin
			status0 = ST_OK;
		end
	end

	assign rx0      = (hdr.dst_ip == local_addr_q);
	assign web_port = rx0 ? hdr.src_port_num : hdr.dst_port_num;
	assign ssh_port = rx0 ? hdr.dst_port_num : hdr.src_port_num;
	assign peer_ip  = rx0 ? hdr.src_ip : hdr.dst_ip;

	always_comb begin
		if (hdr.ip_proto == ProtoUdp && (hdr.src_port_num == target_port_q
				|| hdr.dst_port_num == target_port_q)) begin
			cls0 = CLS_TARGET;
		end else if (hdr.ip_proto == ProtoTcp && web_port == PortHttp) begin
			cls0 = (peer_ip == svc_addr_q) ? CLS_META : CLS_HTTP;
		end else if (hdr.ip_proto == ProtoTcp && ssh_port == PortSsh) begin
			cls0 = CLS_SSH;
		end else if (peer_ip[31:24] == PrivateOctet) begin
			cls0 = CLS_PRIVATE;
		end else begin
			cls0 = CLS_PUBLIC;
		end
	end

	assign sel0      = decode_select(hdr.counter_select);
	assign tot_raddr = (cmd == CMD_READ) ? sel0.dir : rx0;
	assign cls_raddr = (cmd == CMD_READ) ? row_of(sel0.dir, sel0.cls) : row_of(rx0, cls0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1      <= cmd;
			counted_s1  <= (cmd == CMD_COUNT) && (status0 == ST_OK);
			status_s1   <= status0;
			dir_s1      <= (cmd == CMD_COUNT) && (status0 == ST_OK) && rx0;
			cls_s1      <= ((cmd == CMD_COUNT) && (status0 == ST_OK)) ? cls0 : CLS_TOTAL;
			sel_s1      <= sel0;
			bytes_s1    <= {1'b0, hdr.ip_total_len} + 17'(EthHdrBytes);
			tot_addr_s1 <= tot_raddr;
			cls_addr_s1 <= cls_raddr;
			tot_vld_s1  <= tot_vld_q[tot_raddr];
			cls_vld_s1  <= cls_vld_q[cls_raddr];
		end
	end

	pcc_ram #(
		.Width (WordW),
		.Depth (TotRows)
	) u_tot_ram (
		.clk   (clk),
		.we    (tot_we),
		.waddr (tot_addr_s1),
		.wdata (tot_new),
		.re    (accept),
		.raddr (tot_raddr),
		.rdata (tot_rdata)
	);

	pcc_ram #(
		.Width (WordW),
		.Depth (ClsRows)
	) u_cls_ram (
		.clk   (clk),
		.we    (cls_we),
		.waddr (cls_addr_s1),
		.wdata (cls_new),
		.re    (accept),
		.raddr (cls_raddr),
		.rdata (cls_rdata)
	);

	// Second stage: forward the last write, update and write back.
	always_comb begin
		if (tot_fwd_vld_s2 && tot_fwd_addr_s2 == tot_addr_s1) begin
			tot_old = tot_fwd_data_s2;
		end else if (tot_vld_s1) begin
			tot_old = tot_rdata;
		end else begin
			tot_old = '0;
		end
		if (cls_fwd_vld_s2 && cls_fwd_addr_s2 == cls_addr_s1) begin
			cls_old = cls_fwd_data_s2;
		end else if (cls_vld_s1) begin
			cls_old = cls_rdata;
		end else begin
			cls_old = '0;
		end
	end

	assign tot_new.pkts  = tot_old.pkts + 1'b1;
	assign tot_new.bytes = tot_old.bytes + CntW'(bytes_s1);
	assign cls_new.pkts  = cls_old.pkts + 1'b1;
	assign cls_new.bytes = cls_old.bytes + CntW'(bytes_s1);
	assign tot_we        = s1_valid_q && counted_s1;
	assign cls_we        = s1_valid_q && counted_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tot_vld_q      <= '0;
			cls_vld_q      <= '0;
			tot_fwd_vld_s2 <= 1'b0;
			cls_fwd_vld_s2 <= 1'b0;
		end else begin
			tot_fwd_vld_s2 <= tot_we;
			cls_fwd_vld_s2 <= cls_we;
			if (tot_we) begin
				tot_vld_q[tot_addr_s1] <= 1'b1;
			end
			if (cls_we) begin
				cls_vld_q[cls_addr_s1] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tot_we) begin
			tot_fwd_addr_s2 <= tot_addr_s1;
			tot_fwd_data_s2 <= tot_new;
		end
		if (cls_we) begin
			cls_fwd_addr_s2 <= cls_addr_s1;
			cls_fwd_data_s2 <= cls_new;
		end
	end

	assign read_word = (sel_s1.cls == CLS_TOTAL) ? tot_old : cls_old;

	always_comb begin
		res_s1.status     = status_s1;
		res_s1.direction  = dir_s1;
		res_s1.flow_class = cls_s1;
		if (cmd_s1 == CMD_READ && sel_s1.in_range) begin
			res_s1.read_value = sel_s1.kind ? read_word.bytes : read_word.pkts;
		end else begin
			res_s1.read_value = '0;
		end
	end

	pcc_outq #(
		.Depth (OutqDepth)
	) u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (s1_valid_q),
		.push_data (res_s1),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (head),
		.level     (level)
	);

	assign m_tdata = OutTdataW'(head);

	`PCC_ASSERT_IMPL(a_queue_never_overfills, clk, arst_n, 1'b1, fill_sum <= (LvlW + 1)'(OutqDepth))
	`PCC_ASSERT_NEXT(a_accept_enters_stage, clk, arst_n, s_tvalid && s_tready, s1_valid_q)
	`PCC_ASSERT_IMPL(a_read_no_write, clk, arst_n, s1_valid_q && cmd_s1 == CMD_READ, !tot_we && !cls_we)

endmodule

`default_nettype wire

FILE: hdl/pcc_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// A read at the address being written returns the old contents. No dependencies.
`default_nettype none

module pcc_ram #(
	parameter int Width = 8,
	parameter int Depth = 2,
	parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AddrW-1:0] waddr,
	input  wire logic [Width-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AddrW-1:0] raddr,
	output      logic [Width-1:0] rdata
);

	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: hdl/pcc_outq.sv
// Small result queue in front of the output channel; its fill level lets the
// input side keep accepting while the receiver stalls. Depends on pcc_pkg.
`default_nettype none

module pcc_outq #(
	parameter int Depth = 3,
	parameter int LvlW  = $clog2(Depth + 1)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire pcc_pkg::result_t push_data,
	output      logic             out_valid,
	input  wire logic             out_ready,
	output      pcc_pkg::result_t out_data,
	output      logic [LvlW-1:0]  level
);
	import pcc_pkg::*;

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;

	result_t         slot_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [LvlW-1:0] level_q;
	logic            pop;

	function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
		return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
	endfunction

	assign out_valid = (level_q != '0);
	assign out_data  = slot_q[rd_ptr_q];
	assign level     = level_q;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				level_q <= level_q + 1'b1;
			end else if (pop && !push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire
